### rtl/fevsd_pkg.sv
package fevsd_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned SQUARE_W     = 31;
  localparam int unsigned ENERGY_W     = 43;
  localparam int unsigned FRAME_SIZE_W = 13;
  localparam int unsigned OUT_POS_W    = 32;

  // Register port geometry: 64-bit registers at byte addresses 0 and 8.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 64;

  // Register index, taken from address bit 3.
  localparam logic REG_FRAME_SIZE       = 1'b0;
  localparam logic REG_ENERGY_THRESHOLD = 1'b1;

  // Register reset values.
  localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RST       = 13'd512;
  localparam logic [ENERGY_W-1:0]     ENERGY_THRESHOLD_RST = 43'd1048576;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  // One input sample transfer.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_item_t;

  // One result transfer.
  typedef struct packed {
    logic                 voice_found;
    logic [OUT_POS_W-1:0] start_position;
    logic [OUT_POS_W-1:0] span_length;
  } out_item_t;

endpackage

### rtl/fevsd_span.sv
module fevsd_span #(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned FS_W          = 13
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rec_valid_i,
  output logic                            rec_stall_o,
  input  logic                            rec_found_i,
  input  logic [POSITION_BITS-1:0]        rec_first_i,
  input  logic [POSITION_BITS-1:0]        rec_last_i,
  input  logic [FS_W-1:0]                 rec_fs_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output fevsd_pkg::out_item_t            out_item_o
);

  localparam int unsigned OPW  = fevsd_pkg::OUT_POS_W;
  localparam int unsigned EXTW = (POSITION_BITS + 1 > OPW + 1) ? POSITION_BITS + 1 : OPW + 1;
  localparam int unsigned PRW  = OPW + FS_W;
  localparam logic [63:0] LIM  = (POSITION_BITS >= 32) ? 64'hFFFF_FFFF :
                                 ((64'd1 << POSITION_BITS) - 64'd1);

  // Stage valid bits.
  logic v1_q, v2_q, v3_q, vo_q;
  logic free1, free2, free3, freeo;

  // Stage 1: captured recording summary.
  logic                     found1_q;
  logic [POSITION_BITS-1:0] first1_q, last1_q;
  logic [FS_W-1:0]          fs1_q;

  // Stage 2: multiplier operands with overflow flags.
  logic            found2_q, sbig2_q, lbig2_q;
  logic [OPW-1:0]  sop2_q, lop2_q;
  logic [FS_W-1:0] fs2_q;
  logic [EXTW-1:0] first_ext, diff_ext;

  // Stage 3: products.
  logic           found3_q, sbig3_q, lbig3_q;
  logic [PRW-1:0] sprod3_q, lprod3_q;

  // Output register.
  fevsd_pkg::out_item_t out_q;
  logic [63:0]          sprod_ext, lprod_ext;

  // A stage takes a new entry when it is empty or its content moves on.
  assign freeo       = !vo_q || !out_stall_i;
  assign free3       = !v3_q || freeo;
  assign free2       = !v2_q || free3;
  assign free1       = !v1_q || free2;
  assign rec_stall_o = !free1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (free1) v1_q <= rec_valid_i;
      if (free2) v2_q <= v1_q;
      if (free3) v3_q <= v2_q;
      if (freeo) vo_q <= v3_q;
    end
  end

  // Span in frames and a split of each operand into its low 32 bits and an overflow flag.
  // A zero frame size makes every product zero, so it cancels the overflow flags.
  assign first_ext = EXTW'(first1_q);
  assign diff_ext  = EXTW'(last1_q) - EXTW'(first1_q) + EXTW'(1);

  // Products and saturation against the smaller of the position and output ranges.
  assign sprod_ext = 64'(sprod3_q);
  assign lprod_ext = 64'(lprod3_q);

  always_ff @(posedge clk_i) begin
    if (free1 && rec_valid_i) begin
      found1_q <= rec_found_i;
      first1_q <= rec_first_i;
      last1_q  <= rec_last_i;
      fs1_q    <= rec_fs_i;
    end
    if (free2 && v1_q) begin
      found2_q <= found1_q;
      sbig2_q  <= (|first_ext[EXTW-1:OPW]) && (fs1_q != '0);
      lbig2_q  <= (|diff_ext[EXTW-1:OPW]) && (fs1_q != '0);
      sop2_q   <= first_ext[OPW-1:0];
      lop2_q   <= diff_ext[OPW-1:0];
      fs2_q    <= fs1_q;
    end
    if (free3 && v2_q) begin
      found3_q <= found2_q;
      sbig3_q  <= sbig2_q;
      lbig3_q  <= lbig2_q;
      sprod3_q <= PRW'(sop2_q) * PRW'(fs2_q);
      lprod3_q <= PRW'(lop2_q) * PRW'(fs2_q);
    end
    if (freeo && v3_q) begin
      out_q.voice_found <= found3_q;
      if (!found3_q) begin
        out_q.start_position <= '0;
        out_q.span_length    <= '0;
      end else begin
        out_q.start_position <= (sbig3_q || sprod_ext > LIM) ? LIM[OPW-1:0] : sprod_ext[OPW-1:0];
        out_q.span_length    <= (lbig3_q || lprod_ext > LIM) ? LIM[OPW-1:0] : lprod_ext[OPW-1:0];
      end
    end
  end

  assign out_valid_o = vo_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // A recording without voice reports zero position and span.
  a_no_voice_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.voice_found |->
      out_item_o.start_position == '0 && out_item_o.span_length == '0)
    else $error("no-voice result carries a nonzero position or span");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  // The summary is held off only when every result stage is occupied.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_stall_o |-> v1_q && v2_q && v3_q && vo_q && out_stall_i)
    else $error("summary stalled while a result stage is free");
`endif

endmodule

### rtl/frame_energy_voice_span_detector.sv
// Channel   Direction  Handshake               Payload
// samples   in         in_valid_i / in_stall_o   in_item_i  (sample, last_sample)
// results   out        out_valid_o / out_stall_i out_item_o (voice_found, start, span)
// config    in         APB psel/penable/pready   paddr, pwdata, prdata (64-bit registers)
//
// One sample transfer per cycle unless a final sample is held off; each costs
// one square and one accumulate step. A result reaches the output register
// through a four-entry result pipeline (capture, span, multiply, saturate).
// Output stalls only fill that pipeline; samples keep flowing, and a final sample
// waits only while all four result stages are occupied.
// Reset clears the frame state and restores frame length 512 and threshold 1048576.
module frame_energy_voice_span_detector #(
  parameter int unsigned MAX_FRAME_SIZE = 4096,
  parameter int unsigned POSITION_BITS  = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  fevsd_pkg::in_item_t                in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output fevsd_pkg::out_item_t               out_item_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fevsd_pkg::PADDR_W-1:0]      paddr,
  input  logic [fevsd_pkg::PDATA_W-1:0]      pwdata,
  output logic [fevsd_pkg::PDATA_W-1:0]      prdata,
  output logic                               pready
);

  localparam int unsigned FS_W  = $clog2(MAX_FRAME_SIZE + 1);
  localparam int unsigned CMPW  = (FS_W > fevsd_pkg::FRAME_SIZE_W) ? FS_W :
                                  fevsd_pkg::FRAME_SIZE_W;
  localparam int unsigned EW    = fevsd_pkg::ENERGY_W;

  // Configuration registers.
  logic [fevsd_pkg::FRAME_SIZE_W-1:0] fsize_q;
  logic [EW-1:0]                      thr_q;
  logic                               cfg_wr;

  // Input register.
  logic                              s0_valid_q, s0_last_q;
  logic [fevsd_pkg::SQUARE_W-1:0]    s0_sq_q;
  logic signed [2*fevsd_pkg::SAMPLE_W-1:0] sq_full;
  logic                              in_accept, acc_go, acc_fire;

  // Frame state.
  logic [FS_W-1:0]          cnt_q, cnt_d, cnt_inc;
  logic [POSITION_BITS-1:0] idx_q, idx_d;
  logic [EW-1:0]            energy_q, energy_d, energy_sat;
  logic [EW:0]              energy_sum;
  logic                     any_q, any_d;
  logic [POSITION_BITS-1:0] first_q, first_d, lastf_q, lastf_d;
  logic [FS_W-1:0]          fs_eff;
  logic                     frame_done, frame_active;
  logic                     rec_stall;

  // Register writes complete on the access cycle; reads are a plain mux.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsize_q <= fevsd_pkg::FRAME_SIZE_RST;
      thr_q   <= fevsd_pkg::ENERGY_THRESHOLD_RST;
    end else if (cfg_wr) begin
      case (paddr[3])
        fevsd_pkg::REG_FRAME_SIZE:       fsize_q <= pwdata[fevsd_pkg::FRAME_SIZE_W-1:0];
        fevsd_pkg::REG_ENERGY_THRESHOLD: thr_q   <= pwdata[EW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      fevsd_pkg::REG_FRAME_SIZE:       prdata = fevsd_pkg::PDATA_W'(fsize_q);
      fevsd_pkg::REG_ENERGY_THRESHOLD: prdata = fevsd_pkg::PDATA_W'(thr_q);
      default:                         prdata = '0;
    endcase
  end

  // The input register moves on unless a final sample finds the result pipeline full.
  assign acc_go     = !s0_last_q || !rec_stall;
  assign acc_fire   = s0_valid_q && acc_go;
  assign in_stall_o = s0_valid_q && !acc_go;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign sq_full    = in_item_i.sample * in_item_i.sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_accept) begin
      s0_valid_q <= 1'b1;
    end else if (acc_fire) begin
      s0_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s0_sq_q   <= sq_full[fevsd_pkg::SQUARE_W-1:0];
      s0_last_q <= in_item_i.last_sample;
    end
  end

  // Frame size above the supported maximum counts as the maximum.
  assign fs_eff = (CMPW'(fsize_q) > CMPW'(MAX_FRAME_SIZE)) ? FS_W'(MAX_FRAME_SIZE) :
                  FS_W'(fsize_q);

  // Accumulate, saturate and judge the frame when its count reaches the frame size.
  assign energy_sum   = {1'b0, energy_q} + (EW + 1)'(s0_sq_q);
  assign energy_sat   = energy_sum[EW] ? fevsd_pkg::ENERGY_MAX : energy_sum[EW-1:0];
  assign cnt_inc      = cnt_q + FS_W'(1);
  assign frame_done   = (fs_eff != '0) && (cnt_inc >= fs_eff);
  assign frame_active = frame_done && (energy_sat >= thr_q);

  always_comb begin
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    energy_d = energy_q;
    any_d    = any_q;
    first_d  = first_q;
    lastf_d  = lastf_q;
    if (fs_eff != '0) begin
      energy_d = energy_sat;
      cnt_d    = cnt_inc;
      if (frame_done) begin
        if (frame_active) begin
          if (!any_q) begin
            first_d = idx_q;
            any_d   = 1'b1;
          end
          lastf_d = idx_q;
        end
        if (idx_q != '1) begin
          idx_d = idx_q + POSITION_BITS'(1);
        end
        cnt_d    = '0;
        energy_d = '0;
      end
    end
  end

  // A final sample hands the summary on and clears the frame state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      idx_q    <= '0;
      energy_q <= '0;
      any_q    <= 1'b0;
      first_q  <= '0;
      lastf_q  <= '0;
    end else if (acc_fire) begin
      if (s0_last_q) begin
        cnt_q    <= '0;
        idx_q    <= '0;
        energy_q <= '0;
        any_q    <= 1'b0;
        first_q  <= '0;
        lastf_q  <= '0;
      end else begin
        cnt_q    <= cnt_d;
        idx_q    <= idx_d;
        energy_q <= energy_d;
        any_q    <= any_d;
        first_q  <= first_d;
        lastf_q  <= lastf_d;
      end
    end
  end

  // Position and span arithmetic for each finished recording.
  fevsd_span #(
    .POSITION_BITS(POSITION_BITS),
    .FS_W         (FS_W)
  ) u_span (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_valid_i(s0_valid_q && s0_last_q),
    .rec_stall_o(rec_stall),
    .rec_found_i(any_d),
    .rec_first_i(first_d),
    .rec_last_i (lastf_d),
    .rec_fs_i   (fs_eff),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

`ifndef SYNTHESIS
  // Only a final sample waiting on a full result pipeline holds off new samples.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s0_valid_q && s0_last_q && rec_stall)
    else $error("sample stall without a blocked final sample");

  // Frame indices stay clear until the first active frame.
  a_idle_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_q |-> first_q == '0 && lastf_q == '0)
    else $error("active frame marks set without an active frame");

  // The last active frame never precedes the first.
  a_mark_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q |-> first_q <= lastf_q && lastf_q <= idx_q)
    else $error("active frame marks out of order");
`endif

endmodule

### verif/voice_span_checker.sv
`timescale 1ns / 1ps

module voice_span_checker #(
  parameter int unsigned MAX_FRAME_SIZE = 4096,
  parameter int unsigned POSITION_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  fevsd_pkg::in_item_t           in_item_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  fevsd_pkg::out_item_t          out_item_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [fevsd_pkg::PADDR_W-1:0] paddr_i,
  input  logic [fevsd_pkg::PDATA_W-1:0] pwdata_i,
  input  logic [fevsd_pkg::PDATA_W-1:0] prdata_i,
  input  logic                          pready_i,
  output int                            pending_o,
  output int                            fail_count_o
);

  // Highest frame index, and the ceiling that reported positions clip to.
  localparam logic [63:0] POS_MAX   = (64'd1 << POSITION_BITS) - 64'd1;
  localparam logic [63:0] POS_LIMIT = (POS_MAX < 64'hFFFF_FFFF) ? POS_MAX : 64'hFFFF_FFFF;

  // Shadow copy of the registers, updated from observed register writes.
  logic [fevsd_pkg::FRAME_SIZE_W-1:0] cfg_fsize;
  logic [fevsd_pkg::ENERGY_W-1:0]     cfg_threshold;

  // Recording state as the block should hold it.
  int unsigned                    frame_fill;
  logic [63:0]                    frame_num;
  logic [fevsd_pkg::ENERGY_W-1:0] frame_energy;
  logic                           voice_seen;
  logic [63:0]                    first_active;
  logic [63:0]                    last_active;

  fevsd_pkg::out_item_t expected_spans[$];
  int                   mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic clear_recording();
    frame_fill   = 0;
    frame_num    = '0;
    frame_energy = '0;
    voice_seen   = 1'b0;
    first_active = '0;
    last_active  = '0;
  endtask

  // Accumulate one sample; a final sample yields the span summary and clears.
  task automatic take_sample(input fevsd_pkg::in_item_t item);
    int                   level;
    logic [63:0]          square;
    logic [63:0]          total;
    logic [63:0]          fs;
    logic [63:0]          start_pos;
    logic [63:0]          span_len;
    fevsd_pkg::out_item_t summary;
    level  = $signed(item.sample);
    square = 64'(level * level);
    fs = (cfg_fsize > MAX_FRAME_SIZE) ? 64'(MAX_FRAME_SIZE) : 64'(cfg_fsize);
    if (fs != 0) begin
      total        = 64'(frame_energy) + square;
      frame_energy = (total > 64'(fevsd_pkg::ENERGY_MAX)) ? fevsd_pkg::ENERGY_MAX
                                                          : total[fevsd_pkg::ENERGY_W-1:0];
      frame_fill++;
      // A full frame is judged against the threshold, then the next starts empty.
      if (64'(frame_fill) >= fs) begin
        if (frame_energy >= cfg_threshold) begin
          if (!voice_seen) begin
            first_active = frame_num;
            voice_seen   = 1'b1;
          end
          last_active = frame_num;
        end
        if (frame_num < POS_MAX) frame_num++;
        frame_fill   = 0;
        frame_energy = '0;
      end
    end
    if (item.last_sample) begin
      summary = '0;
      if (voice_seen) begin
        start_pos = first_active * fs;
        span_len  = (last_active - first_active + 64'd1) * fs;
        summary.voice_found    = 1'b1;
        summary.start_position = (start_pos > POS_LIMIT)
                                 ? POS_LIMIT[fevsd_pkg::OUT_POS_W-1:0]
                                 : start_pos[fevsd_pkg::OUT_POS_W-1:0];
        summary.span_length    = (span_len > POS_LIMIT)
                                 ? POS_LIMIT[fevsd_pkg::OUT_POS_W-1:0]
                                 : span_len[fevsd_pkg::OUT_POS_W-1:0];
      end
      expected_spans.push_back(summary);
      clear_recording();
    end
  endtask

  task automatic check_result(input fevsd_pkg::out_item_t got);
    fevsd_pkg::out_item_t want;
    if (expected_spans.size() == 0) begin
      report_mismatch("unexpected result (start, span)", 64'(got.start_position),
                      64'(got.span_length));
    end else begin
      want = expected_spans.pop_front();
      if (got.voice_found !== want.voice_found)
        report_mismatch("voice_found", 64'(got.voice_found), 64'(want.voice_found));
      if (got.start_position !== want.start_position)
        report_mismatch("start_position", 64'(got.start_position), 64'(want.start_position));
      if (got.span_length !== want.span_length)
        report_mismatch("span_length", 64'(got.span_length), 64'(want.span_length));
    end
  endtask

  // Results are checked before new samples so a fresh expectation is never
  // matched against a result already in flight.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_fsize     = fevsd_pkg::FRAME_SIZE_RST;
      cfg_threshold = fevsd_pkg::ENERGY_THRESHOLD_RST;
      clear_recording();
      expected_spans.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i[3] == fevsd_pkg::REG_FRAME_SIZE)
            cfg_fsize = pwdata_i[fevsd_pkg::FRAME_SIZE_W-1:0];
          else
            cfg_threshold = pwdata_i[fevsd_pkg::ENERGY_W-1:0];
        end else if (paddr_i[3] == fevsd_pkg::REG_FRAME_SIZE) begin
          if (prdata_i !== 64'(cfg_fsize))
            report_mismatch("frame length readback", prdata_i, 64'(cfg_fsize));
        end else if (prdata_i !== 64'(cfg_threshold)) begin
          report_mismatch("energy threshold readback", prdata_i, 64'(cfg_threshold));
        end
      end
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      if (in_valid_i && !in_stall_i) take_sample(in_item_i);
      pending_o <= expected_spans.size();
    end
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

  // A small frame limit keeps the clamped recordings short.
  localparam int unsigned MAX_FRAME_SIZE = 64;
  localparam int unsigned POSITION_BITS  = 32;
  localparam int          RANDOM_SAMPLES = 350;
  localparam int          SETTLE_CYCLES  = 16;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          IDLE_LIMIT     = 4000;

  localparam logic [fevsd_pkg::PADDR_W-1:0] ADDR_FRAME_SIZE =
    {fevsd_pkg::REG_FRAME_SIZE, 3'b000};
  localparam logic [fevsd_pkg::PADDR_W-1:0] ADDR_ENERGY_THRESHOLD =
    {fevsd_pkg::REG_ENERGY_THRESHOLD, 3'b000};

  localparam logic signed [fevsd_pkg::SAMPLE_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [fevsd_pkg::SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  // One full-scale sample squared: a frame holding just that is exactly at threshold.
  localparam logic [fevsd_pkg::ENERGY_W-1:0] THR_EDGE = 43'd1073676289;

  logic                          clk_i    = 1'b0;
  logic                          rst_ni   = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  fevsd_pkg::in_item_t           in_item  = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  fevsd_pkg::out_item_t          out_item;
  logic                          psel     = 1'b0;
  logic                          penable  = 1'b0;
  logic                          pwrite   = 1'b0;
  logic [fevsd_pkg::PADDR_W-1:0] paddr    = '0;
  logic [fevsd_pkg::PDATA_W-1:0] pwdata   = '0;
  logic [fevsd_pkg::PDATA_W-1:0] prdata;
  logic                          pready;
  int                            pending;
  int                            fail_count;

  int samples_sent    = 0;
  int recordings_done = 0;
  int reg_writes      = 0;
  int burst_left      = 1;
  int idle_cycles     = 0;
  bit steady          = 1'b0;
  bit hold_req        = 1'b0;

  always #5 clk_i = ~clk_i;

  frame_energy_voice_span_detector #(
    .MAX_FRAME_SIZE(MAX_FRAME_SIZE),
    .POSITION_BITS (POSITION_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  voice_span_checker #(
    .MAX_FRAME_SIZE(MAX_FRAME_SIZE),
    .POSITION_BITS (POSITION_BITS)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .pready_i    (pready),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  // Register access: setup phase, access phase, then a return to idle.
  task automatic apb_access(input logic is_write, input logic [fevsd_pkg::PADDR_W-1:0] addr,
                            input logic [fevsd_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (is_write) reg_writes++;
  endtask

  // Offer one sample and hold it until the transfer happens.
  task automatic send_sample(input logic signed [fevsd_pkg::SAMPLE_W-1:0] value,
                             input logic last);
    fevsd_pkg::in_item_t item;
    int                  gap;
    item.sample      = value;
    item.last_sample = last;
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    samples_sent++;
    burst_left--;
    // Bursts of random length, each followed by a random pause.
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stop offering samples until every expected result is out, then let the
  // pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [fevsd_pkg::FRAME_SIZE_W-1:0] size,
                            input logic [fevsd_pkg::ENERGY_W-1:0] thr);
    logic [fevsd_pkg::PDATA_W-1:0] junk;
    drain();
    // Bits above a register's width are sometimes set; they must be dropped.
    junk = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
    apb_access(1'b1, ADDR_FRAME_SIZE,
               {junk[fevsd_pkg::PDATA_W-1:fevsd_pkg::FRAME_SIZE_W], size});
    apb_access(1'b1, ADDR_ENERGY_THRESHOLD,
               {junk[fevsd_pkg::PDATA_W-1:fevsd_pkg::ENERGY_W], thr});
    apb_access(1'b0, ADDR_FRAME_SIZE, '0);
    apb_access(1'b0, ADDR_ENERGY_THRESHOLD, '0);
    steady = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_recording(input int unsigned fs, input int unsigned frames,
                                input int unsigned tail, input bit finish);
    int unsigned        total;
    int                 limit;
    int                 mag;
    logic signed [15:0] value;
    total = fs * frames + tail;
    if (total == 0) total = 1;
    limit = 32768;
    for (int unsigned n = 0; n < total; n++) begin
      // Each frame draws its own loudness so frame activity varies.
      if (fs == 0 || n % fs == 0) begin
        case ($urandom_range(0, 3))
          0: limit = $urandom_range(0, 16);
          1: limit = 256;
          2: limit = $urandom_range(1, 32768);
          default: limit = 32768;
        endcase
      end
      mag = $urandom_range(0, limit);
      if ($urandom_range(0, 1)) value = 16'(-mag);
      else value = (mag > 32767) ? S_MAX : 16'(mag);
      send_sample(value, finish && (n == total - 1));
    end
    if (finish) recordings_done++;
  endtask

  // Receiver: segments of no stall, light, periodic or heavy stalling, and a
  // long hold-off on request.
  initial begin : receiver
    int unsigned seg_left;
    int unsigned mode;
    int unsigned period;
    int unsigned tick;
    int unsigned hold_left;
    seg_left  = 0;
    mode      = 0;
    period    = 2;
    tick      = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 200);
          mode     = $urandom_range(0, 3);
          period   = $urandom_range(2, 7);
        end
        seg_left--;
        tick++;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= (tick % period != 0);
          default: out_stall <= ($urandom_range(0, 99) < 80);
        endcase
      end
    end
  end

  // Watchdog: too many cycles with no transfer and no register access.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic signed [fevsd_pkg::SAMPLE_W-1:0] opening [17];
    logic [fevsd_pkg::FRAME_SIZE_W-1:0]    size;
    logic [fevsd_pkg::ENERGY_W-1:0]        thr;
    int unsigned                           size_eff;
    int unsigned                           level;
    int unsigned                           records;
    int unsigned                           frames;
    int unsigned                           tail;
    int                                    phase;
    int                                    random_count;
    bit                                    finish;
    phase        = 0;
    random_count = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Registers must read back their reset values.
    apb_access(1'b0, ADDR_FRAME_SIZE, '0);
    apb_access(1'b0, ADDR_ENERGY_THRESHOLD, '0);

    // Quiet, loud, quiet, then a frame exactly at threshold, and a loud
    // partial frame at the end that must not count.
    set_config(13'd4, THR_EDGE);
    opening = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, S_MIN, S_MAX, 16'sd0, 16'sd0,
                16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, S_MAX, S_MIN};
    foreach (opening[i]) send_sample(opening[i], i == 16);
    recordings_done++;
    // A recording shorter than one frame reports no voice.
    send_sample(S_MAX, 1'b1);
    recordings_done++;
    // The final sample completes a loud frame that must still be judged.
    repeat (3) send_sample(16'sd0, 1'b0);
    send_sample(S_MIN, 1'b1);
    recordings_done++;

    // Zero frame size gathers nothing.
    set_config(13'd0, THR_EDGE);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MIN, 1'b1);
    recordings_done++;

    // Frame size shrinks while a frame is partly filled.
    set_config(13'd4, THR_EDGE);
    repeat (3) send_sample(S_MIN, 1'b0);
    set_config(13'd2, THR_EDGE);
    send_sample(16'sd0, 1'b1);
    recordings_done++;

    // Results pile up behind a long output hold-off while samples keep coming.
    set_config(13'd1, '0);
    steady   = 1'b1;
    hold_req = 1'b1;
    repeat (24) send_recording(1, 1, 0, 1'b1);

    // Oversized frame size clamps to the maximum; then the maximum itself.
    set_config(13'h1FFF, 43'd1 << 32);
    send_recording(MAX_FRAME_SIZE, 2, 3, 1'b1);
    set_config(13'(MAX_FRAME_SIZE), 43'd1 << 32);
    send_recording(MAX_FRAME_SIZE, 2, 0, 1'b1);

    // Random phases of small frames; thresholds at both extremes first.
    while (random_count < RANDOM_SAMPLES) begin
      case ($urandom_range(0, 9))
        0: size = 13'd1;
        1: size = 13'd0;
        default: size = 13'($urandom_range(2, 12));
      endcase
      size_eff = size;
      level    = $urandom_range(0, 32767);
      case (phase)
        0: thr = '0;
        1: thr = fevsd_pkg::ENERGY_MAX;
        default: thr = fevsd_pkg::ENERGY_W'(64'(size_eff) * 64'(level) * 64'(level));
      endcase
      set_config(size, thr);
      records = $urandom_range(2, 8);
      for (int r = 0; r < records; r++) begin
        frames = $urandom_range(0, 5);
        if (size_eff == 0) tail = $urandom_range(1, 20);
        else if ($urandom_range(0, 2) == 0) tail = 0;
        else tail = $urandom_range(0, size_eff - 1);
        // Now and then the phase ends inside a recording, so the next frame
        // size takes effect mid-frame.
        finish = (r != records - 1) || ($urandom_range(0, 3) != 0);
        send_recording(size_eff, frames, tail, finish);
        if (size_eff != 0) random_count += size_eff * frames + tail;
      end
      phase++;
    end

    // Close any recording left open, then wait for the last results.
    send_sample(16'sd0, 1'b1);
    recordings_done++;
    drain();

    $display("Covered %0d samples in %0d recordings across %0d register writes,",
             samples_sent, recordings_done, reg_writes);
    $display("with zero, clamped and mid-frame frame sizes and a long output hold-off.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
